@@ rtl/mrg_pkg.sv @@
package mrg_pkg;

    localparam int MAX_COLUMNS_DEF = 32;
    localparam int LABEL_W         = 6;
    localparam int CFG_W           = 6;
    localparam int RIGHT_W         = 31;
    localparam int BOTTOM_W        = 32;
    localparam logic [LABEL_W-1:0] LABEL_NONE = '0;
    localparam logic [LABEL_W-1:0] LABEL_FIRST = LABEL_W'(1);
    localparam logic [LABEL_W-1:0] LABEL_MAX = '1;
    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(32);

    typedef struct packed {
        logic [RIGHT_W-1:0]  right_wish;
        logic [BOTTOM_W-1:0] bottom_wish;
        logic                last_row;
    } in_t;

    typedef struct packed {
        logic [RIGHT_W-1:0]  right_walls;
        logic [BOTTOM_W-1:0] bottom_walls;
        logic                row_is_last;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRESH,
        ST_LEFT,
        ST_RIGHT,
        ST_BOTTOM,
        ST_HOLE,
        ST_EMPTY,
        ST_LEFT2,
        ST_FINAL,
        ST_CLOSE,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FRESH,
        OP_LEFT,
        OP_RIGHT,
        OP_BOTTOM,
        OP_HOLE,
        OP_EMPTY,
        OP_FINAL,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic advance;
        logic at_last;
        logic at_pair_last;
        logic w_one;
        logic last;
    } status_t;

endpackage

@@ rtl/mrg_ctrl.sv @@
module mrg_ctrl #(
    parameter int MAX_COLUMNS = mrg_pkg::MAX_COLUMNS_DEF,
    localparam int CW = $clog2(MAX_COLUMNS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             out_free,
    input  mrg_pkg::status_t status,
    output mrg_pkg::cmd_t    cmd,
    output logic [CW-1:0]    idx,
    output logic             idle
);

    mrg_pkg::state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrg_pkg::ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.op       = mrg_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            mrg_pkg::ST_IDLE: begin
                if (start) begin
                    cmd.op     = mrg_pkg::OP_LOAD;
                    idx_next   = '0;
                    state_next = mrg_pkg::ST_FRESH;
                end
            end
            mrg_pkg::ST_FRESH: begin
                cmd.op = mrg_pkg::OP_FRESH;
                if (status.advance) begin
                    idx_next = CW'(idx_reg + 1'b1);
                    if (status.at_last) begin
                        state_next = mrg_pkg::ST_LEFT;
                    end
                end
            end
            mrg_pkg::ST_LEFT: begin
                cmd.op   = mrg_pkg::OP_LEFT;
                idx_next = '0;
                if (!status.w_one) begin
                    state_next = mrg_pkg::ST_RIGHT;
                end else if (status.last) begin
                    state_next = mrg_pkg::ST_CLOSE;
                end else begin
                    state_next = mrg_pkg::ST_BOTTOM;
                end
            end
            mrg_pkg::ST_RIGHT: begin
                cmd.op   = mrg_pkg::OP_RIGHT;
                idx_next = CW'(idx_reg + 1'b1);
                if (status.at_pair_last) begin
                    idx_next   = '0;
                    state_next = status.last ? mrg_pkg::ST_LEFT2 : mrg_pkg::ST_BOTTOM;
                end
            end
            mrg_pkg::ST_BOTTOM: begin
                cmd.op   = mrg_pkg::OP_BOTTOM;
                idx_next = CW'(idx_reg + 1'b1);
                if (status.at_last) begin
                    idx_next   = '0;
                    state_next = mrg_pkg::ST_HOLE;
                end
            end
            mrg_pkg::ST_HOLE: begin
                cmd.op   = mrg_pkg::OP_HOLE;
                idx_next = CW'(idx_reg + 1'b1);
                if (status.at_last) begin
                    idx_next   = '0;
                    state_next = mrg_pkg::ST_EMPTY;
                end
            end
            mrg_pkg::ST_EMPTY: begin
                cmd.op     = mrg_pkg::OP_EMPTY;
                state_next = mrg_pkg::ST_DONE;
            end
            mrg_pkg::ST_LEFT2: begin
                cmd.op     = mrg_pkg::OP_LEFT;
                idx_next   = '0;
                state_next = mrg_pkg::ST_FINAL;
            end
            mrg_pkg::ST_FINAL: begin
                cmd.op   = mrg_pkg::OP_FINAL;
                idx_next = CW'(idx_reg + 1'b1);
                if (status.at_pair_last) begin
                    idx_next   = '0;
                    state_next = mrg_pkg::ST_CLOSE;
                end
            end
            mrg_pkg::ST_CLOSE: begin
                cmd.op     = mrg_pkg::OP_CLOSE;
                state_next = mrg_pkg::ST_DONE;
            end
            mrg_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = mrg_pkg::ST_IDLE;
                end
            end
            default: state_next = mrg_pkg::ST_IDLE;
        endcase
    end

    assign idx  = idx_reg;
    assign idle = (state_reg == mrg_pkg::ST_IDLE);

endmodule

@@ rtl/mrg_datapath.sv @@
module mrg_datapath #(
    parameter int MAX_COLUMNS = mrg_pkg::MAX_COLUMNS_DEF,
    localparam int CW = $clog2(MAX_COLUMNS),
    localparam int WW = $clog2(MAX_COLUMNS + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mrg_pkg::cmd_t              cmd,
    input  logic [CW-1:0]              idx,
    input  mrg_pkg::in_t               in_data,
    input  logic [mrg_pkg::CFG_W-1:0]  maze_width,
    output mrg_pkg::status_t           status,
    output mrg_pkg::out_t              result
);

    localparam int LW = mrg_pkg::LABEL_W;
    localparam int EW = (MAX_COLUMNS > mrg_pkg::BOTTOM_W) ? MAX_COLUMNS : mrg_pkg::BOTTOM_W;

    logic [LW-1:0] lab_reg [MAX_COLUMNS];
    logic [LW-1:0] lab_next [MAX_COLUMNS];
    logic [LW-1:0] left_reg, left_next;
    logic [LW-1:0] cand_reg, cand_next;
    logic [MAX_COLUMNS-1:0] rwish_reg, rwish_next;
    logic [MAX_COLUMNS-1:0] bwish_reg, bwish_next;
    logic [MAX_COLUMNS-1:0] rwall_reg, rwall_next;
    logic [MAX_COLUMNS-1:0] bwall_reg, bwall_next;
    logic                   last_reg, last_next;
    logic [WW-1:0]          w_reg, w_next;

    logic [CW-1:0] rd_addr;
    logic [LW-1:0] rd;
    logic          cand_used, share, hole, wall;
    logic [EW-1:0] rw_ext, bw_ext, rwall_ext, bwall_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_COLUMNS; k++) begin
                lab_reg[k] <= mrg_pkg::LABEL_NONE;
            end
        end else begin
            for (int k = 0; k < MAX_COLUMNS; k++) begin
                lab_reg[k] <= lab_next[k];
            end
        end
        left_reg  <= left_next;
        cand_reg  <= cand_next;
        rwish_reg <= rwish_next;
        bwish_reg <= bwish_next;
        rwall_reg <= rwall_next;
        bwall_reg <= bwall_next;
        last_reg  <= last_next;
        w_reg     <= w_next;
    end

    assign rw_ext = EW'(in_data.right_wish);
    assign bw_ext = EW'(in_data.bottom_wish);

    always_comb begin
        rd_addr = ((cmd.op == mrg_pkg::OP_RIGHT) || (cmd.op == mrg_pkg::OP_FINAL)) ?
                  CW'(idx + 1'b1) : idx;
        rd        = lab_reg[rd_addr];
        cand_used = 1'b0;
        share     = 1'b0;
        hole      = 1'b0;
        for (int k = 0; k < MAX_COLUMNS; k++) begin
            if (lab_reg[k] == cand_reg) cand_used = 1'b1;
            if ((lab_reg[k] == rd) && (CW'(k) != idx)) share = 1'b1;
            if ((lab_reg[k] == rd) && !bwall_reg[k]) hole = 1'b1;
        end
        wall = rwish_reg[idx] || (left_reg == rd);

        for (int k = 0; k < MAX_COLUMNS; k++) begin
            lab_next[k] = lab_reg[k];
        end
        left_next  = left_reg;
        cand_next  = cand_reg;
        rwish_next = rwish_reg;
        bwish_next = bwish_reg;
        rwall_next = rwall_reg;
        bwall_next = bwall_reg;
        last_next  = last_reg;
        w_next     = w_reg;

        unique case (cmd.op)
            mrg_pkg::OP_LOAD: begin
                rwish_next = rw_ext[MAX_COLUMNS-1:0];
                rwish_next[MAX_COLUMNS-1] = (MAX_COLUMNS - 1 < mrg_pkg::RIGHT_W) ?
                                            rw_ext[MAX_COLUMNS-1] : 1'b0;
                bwish_next = bw_ext[MAX_COLUMNS-1:0];
                last_next  = in_data.last_row;
                cand_next  = mrg_pkg::LABEL_FIRST;
                rwall_next = '0;
                bwall_next = '0;
                if (maze_width == '0) begin
                    w_next = WW'(1);
                end else if (int'(maze_width) > MAX_COLUMNS) begin
                    w_next = WW'(MAX_COLUMNS);
                end else begin
                    w_next = WW'(maze_width);
                end
                for (int k = 0; k < MAX_COLUMNS; k++) begin
                    if (k >= int'(w_next)) lab_next[k] = mrg_pkg::LABEL_NONE;
                end
            end
            mrg_pkg::OP_FRESH: begin
                if (rd == mrg_pkg::LABEL_NONE) begin
                    if (cand_used && (cand_reg != mrg_pkg::LABEL_MAX)) begin
                        cand_next = LW'(cand_reg + 1'b1);
                    end else begin
                        lab_next[idx] = cand_reg;
                    end
                end
            end
            mrg_pkg::OP_LEFT: left_next = lab_reg[0];
            mrg_pkg::OP_RIGHT: begin
                if (wall) begin
                    rwall_next[idx] = 1'b1;
                    left_next       = rd;
                end else begin
                    for (int k = 0; k < MAX_COLUMNS; k++) begin
                        if (lab_reg[k] == rd) lab_next[k] = left_reg;
                    end
                end
            end
            mrg_pkg::OP_FINAL: begin
                if (left_reg != rd) begin
                    rwall_next[idx] = 1'b0;
                    for (int k = 0; k < MAX_COLUMNS; k++) begin
                        if (lab_reg[k] == rd) lab_next[k] = left_reg;
                    end
                end
            end
            mrg_pkg::OP_BOTTOM: bwall_next[idx] = bwish_reg[idx] && share;
            mrg_pkg::OP_HOLE: begin
                if (!hole) bwall_next[idx] = 1'b0;
            end
            mrg_pkg::OP_EMPTY: begin
                for (int k = 0; k < MAX_COLUMNS; k++) begin
                    if (bwall_reg[k]) lab_next[k] = mrg_pkg::LABEL_NONE;
                end
            end
            mrg_pkg::OP_CLOSE: begin
                for (int k = 0; k < MAX_COLUMNS; k++) begin
                    bwall_next[k] = (k < int'(w_reg));
                    lab_next[k]   = mrg_pkg::LABEL_NONE;
                end
            end
            default: ;
        endcase
    end

    assign status.advance      = (rd != mrg_pkg::LABEL_NONE) || !cand_used ||
                                 (cand_reg == mrg_pkg::LABEL_MAX);
    assign status.at_last      = (WW'(idx) + WW'(1)) == w_reg;
    assign status.at_pair_last = (WW'(idx) + WW'(2)) == w_reg;
    assign status.w_one        = (w_reg == WW'(1));
    assign status.last         = last_reg;

    assign rwall_ext = EW'(rwall_reg);
    assign bwall_ext = EW'(bwall_reg);
    assign result.right_walls  = rwall_ext[mrg_pkg::RIGHT_W-1:0];
    assign result.bottom_walls = bwall_ext[mrg_pkg::BOTTOM_W-1:0];
    assign result.row_is_last  = last_reg;

endmodule

@@ rtl/maze_row_generator_unit.sv @@
// steps per row: column-serial fresh, merge, bottom and hole passes over the w columns in use;
//   the last row runs fresh, merge, final merge and close passes instead of bottom and hole
// throughput: one row at a time, the next transaction taken once the row is handed over
// the result register lets a new transaction start while a result waits
// reset: synchronous active low, clears all set labels and the controller, width back to 32
module maze_row_generator_unit #(
    parameter int MAX_COLUMNS = mrg_pkg::MAX_COLUMNS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  mrg_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output mrg_pkg::out_t             m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [mrg_pkg::CFG_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_COLUMNS);

    logic [mrg_pkg::CFG_W-1:0] width_reg;
    logic                      m_valid_reg;
    mrg_pkg::out_t             m_data_reg;
    mrg_pkg::cmd_t             cmd;
    mrg_pkg::status_t          status;
    mrg_pkg::out_t             result;
    logic [CW-1:0]             idx;
    logic                      idle, out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= mrg_pkg::WIDTH_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) width_reg <= cfg_data;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (cmd.out_load) m_data_reg <= result;
    end

    mrg_ctrl #(.MAX_COLUMNS(MAX_COLUMNS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .idx      (idx),
        .idle     (idle)
    );

    mrg_datapath #(.MAX_COLUMNS(MAX_COLUMNS)) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .idx        (idx),
        .in_data    (s_data),
        .maze_width (width_reg),
        .status     (status),
        .result     (result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new transaction accepted while a row is in progress");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !(m_valid && !$past(m_valid)))
        else $error("result appeared right after accepting a transaction");

    a_last_row_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.row_is_last |-> m_data.bottom_walls[0])
        else $error("last row lacks closing bottom walls");

endmodule

@@ verif/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOL = mrg_pkg::MAX_COLUMNS_DEF;
    localparam int LW = mrg_pkg::LABEL_W;
    localparam int CFW = mrg_pkg::CFG_W;
    localparam int CYCLE_LIMIT = 1500000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    mrg_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    mrg_pkg::out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFW-1:0] cfg_data = '0;

    always #4 aclk = ~aclk;

    maze_row_generator_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    logic [LW-1:0] set_of [NCOL];
    logic [CFW-1:0] width_reg;
    mrg_pkg::out_t walls_due [$];
    int errors = 0;
    int rows_sent = 0;
    int rows_seen = 0;
    int cycles = 0;
    int widths_used = 0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    function automatic logic [LW-1:0] free_label(int w);
        logic [63:0] taken;
        taken = '0;
        for (int k = 0; k < w; k++) taken[set_of[k]] = 1'b1;
        for (int k = 1; k < 64; k++) if (!taken[k]) return LW'(k);
        return mrg_pkg::LABEL_MAX;
    endfunction

    function automatic void join_sets(int w, logic [LW-1:0] src, logic [LW-1:0] dst);
        for (int k = 0; k < w; k++) if (set_of[k] == src) set_of[k] = dst;
    endfunction

    function automatic mrg_pkg::out_t carve_row(mrg_pkg::in_t row);
        mrg_pkg::out_t r;
        int w;
        int members;
        bit hole;
        r = '0;
        w = int'(width_reg);
        if (w < 1) w = 1;
        if (w > NCOL) w = NCOL;
        for (int j = w; j < NCOL; j++) set_of[j] = mrg_pkg::LABEL_NONE;
        for (int j = 0; j < w; j++)
            if (set_of[j] == mrg_pkg::LABEL_NONE) set_of[j] = free_label(w);
        for (int j = 0; j + 1 < w; j++) begin
            if (row.right_wish[j] || set_of[j] == set_of[j+1]) r.right_walls[j] = 1'b1;
            else join_sets(w, set_of[j+1], set_of[j]);
        end
        for (int j = 0; j < w; j++) begin
            members = 0;
            for (int l = 0; l < w; l++) if (set_of[l] == set_of[j]) members++;
            if (row.bottom_wish[j] && members != 1) r.bottom_walls[j] = 1'b1;
        end
        if (!row.last_row) begin
            for (int j = 0; j < w; j++) begin
                hole = 1'b0;
                for (int l = 0; l < w; l++)
                    if (set_of[l] == set_of[j] && !r.bottom_walls[l]) hole = 1'b1;
                if (!hole) r.bottom_walls[j] = 1'b0;
            end
            for (int j = 0; j < w; j++)
                if (r.bottom_walls[j]) set_of[j] = mrg_pkg::LABEL_NONE;
        end else begin
            for (int j = 0; j + 1 < w; j++) begin
                if (set_of[j] != set_of[j+1]) begin
                    r.right_walls[j] = 1'b0;
                    join_sets(w, set_of[j+1], set_of[j]);
                end
            end
            r.bottom_walls = '0;
            for (int j = 0; j < w; j++) r.bottom_walls[j] = 1'b1;
            for (int j = 0; j < NCOL; j++) set_of[j] = mrg_pkg::LABEL_NONE;
        end
        r.row_is_last = row.last_row;
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("row %0d: %s got %h want %h", rows_seen, what, got, want);
        errors++;
    endtask

    // valid stays high from one transaction to the next unless a gap is drawn
    task automatic send_row(mrg_pkg::in_t row, bit typed, mrg_pkg::out_t want);
        mrg_pkg::out_t p;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        p = carve_row(row);
        if (typed && p !== want) report("predictor", p, want);
        walls_due = {walls_due, (typed ? want : p)};
        s_data <= row;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        rows_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (walls_due.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic set_width(logic [CFW-1:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg = v;
        widths_used++;
    endtask

    function automatic mrg_pkg::in_t rand_row(int lastpct);
        mrg_pkg::in_t r;
        r.right_wish = mrg_pkg::RIGHT_W'({$urandom(), $urandom()});
        r.bottom_wish = $urandom();
        if ($urandom_range(0, 3) == 0) r.right_wish = '0;
        if ($urandom_range(0, 5) == 0) r.bottom_wish = '1;
        r.last_row = ($urandom_range(0, 99) < lastpct);
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("maze_row_generator_unit: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (walls_due.size() == 0) begin
                report("unexpected row", m_data, '0);
            end else begin
                if (m_data.right_walls !== walls_due[0].right_walls)
                    report("right_walls", m_data.right_walls, walls_due[0].right_walls);
                if (m_data.bottom_walls !== walls_due[0].bottom_walls)
                    report("bottom_walls", m_data.bottom_walls, walls_due[0].bottom_walls);
                if (m_data.row_is_last !== walls_due[0].row_is_last)
                    report("row_is_last", m_data.row_is_last, walls_due[0].row_is_last);
                void'(walls_due.pop_front());
            end
            rows_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else if (calm) m_ready <= 1'b1;
        else if (!m_ready) m_ready <= ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
        else m_ready <= ($urandom_range(0, 5) == 0) ? 1'b0 : 1'b1;
    end

    // long receiver stall in its own process
    initial begin
        wait (rows_sent == 100);
        hold_off = 1'b1;
        repeat (1500) @(posedge aclk);
        hold_off = 1'b0;
    end

    typedef struct {
        mrg_pkg::in_t row;
        bit typed;
        mrg_pkg::out_t want;
    } step_t;

    step_t plan [9];
    logic [CFW-1:0] widths [7] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd5, 6'd33};

    initial begin
        for (int k = 0; k < NCOL; k++) set_of[k] = mrg_pkg::LABEL_NONE;
        width_reg = mrg_pkg::WIDTH_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at the reset width
        plan = '{
            '{'{'1, '1, 1'b0}, 1'b1, '{'1, 32'h0, 1'b0}},
            '{'{'0, '0, 1'b0}, 1'b0, '0},
            '{'{'0, '1, 1'b0}, 1'b0, '0},
            '{'{'1, '0, 1'b0}, 1'b0, '0},
            '{'{31'h55555555, 32'haaaaaaaa, 1'b0}, 1'b0, '0},
            '{'{31'h2aaaaaaa, 32'h55555555, 1'b0}, 1'b0, '0},
            '{'{'1, '1, 1'b1}, 1'b1, '{31'h0, '1, 1'b1}},
            '{'{'1, '1, 1'b1}, 1'b1, '{31'h0, '1, 1'b1}},
            '{'{'0, '1, 1'b1}, 1'b1, '{31'h0, '1, 1'b1}}
        };
        foreach (plan[i]) send_row(plan[i].row, plan[i].typed, plan[i].want);
        drain();

        // width extremes and out of range values
        foreach (widths[i]) begin
            set_width(widths[i]);
            send_row('{'1, '1, 1'b0}, 1'b0, '0);
            send_row('{'0, '1, 1'b0}, 1'b0, '0);
            send_row('{'1, '0, 1'b1}, 1'b0, '0);
            drain();
        end

        // random mazes, mostly small widths
        for (int ph = 0; ph < 10; ph++) begin
            set_width((ph % 4 == 3) ? CFW'($urandom_range(0, 63)) :
                      CFW'($urandom_range(1, 8)));
            if (ph == 9) calm = 1'b1;
            repeat (70) send_row(rand_row(ph == 4 ? 50 : 12), 1'b0, '0);
            drain();
        end
        // width change mid maze
        set_width(6'd7);
        repeat (5) send_row(rand_row(0), 1'b0, '0);
        drain();
        set_width(6'd3);
        repeat (5) send_row(rand_row(20), 1'b0, '0);
        drain();

        $display("carved %0d rows over %0d width settings, %0d rows checked",
                 rows_sent, widths_used, rows_seen);
        if (errors == 0 && walls_due.size() == 0) begin
            $display("maze_row_generator_unit: match");
        end else begin
            $display("maze_row_generator_unit: mismatch");
        end
        $finish;
    end
endmodule
